// File: hw/rtl/lsd_radix_sort_top_defines.svh
`ifndef LSD_RADIX_SORT_TOP_DEFINES_SVH
`define LSD_RADIX_SORT_TOP_DEFINES_SVH

// assertion sampled on the block clock, held off during reset
`define LSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: antecedent, then consequent in the next cycle
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lsd_pkg.sv
package lsd_pkg;

  localparam int unsigned KeyW     = 31;
  localparam int unsigned Radix    = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxItems = 64;

  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] q;
  } entry_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] q;
  } dig_req_t;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [KeyW-1:0]   quot;
    logic [DigitW-1:0] digit;
  } dig_rsp_t;

endpackage

// File: hw/rtl/lsd_if.sv
interface lsd_in_if;
  import lsd_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;
  logic            last;
  modport source (output valid, key, last, input ready);
  modport sink (input valid, key, last, output ready);
endinterface

interface lsd_out_if;
  import lsd_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] sorted_key;
  logic            final_res;
  logic            overflow;
  modport source (output valid, sorted_key, final_res, overflow, input ready);
  modport sink (input valid, sorted_key, final_res, overflow, output ready);
endinterface

// File: hw/rtl/lsd_mem.sv
module lsd_mem #(
  parameter int unsigned Depth = lsd_pkg::MaxItems,
  parameter int unsigned AddrW = $clog2(lsd_pkg::MaxItems)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  lsd_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output lsd_pkg::entry_t      rdata_o
);
  import lsd_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lsd_digit.sv
module lsd_digit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsd_pkg::dig_req_t req_i,
  output lsd_pkg::dig_rsp_t rsp_o
);
  import lsd_pkg::*;

  logic [62:0]     prod;
  logic            valid_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] q_q;
  logic [KeyW-1:0] quot_q;
  logic [KeyW-1:0] rem;

  assign prod = 63'(req_i.q) * 63'(Recip10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= req_i.key;
    q_q    <= req_i.q;
    quot_q <= KeyW'(prod[62:35]);
  end

  assign rem = q_q - ((quot_q << 3) + (quot_q << 1));

  assign rsp_o.valid = valid_q;
  assign rsp_o.key   = key_q;
  assign rsp_o.quot  = quot_q;
  assign rsp_o.digit = rem[DigitW-1:0];

endmodule

// File: hw/rtl/lsd_radix_sort_top.sv
// channel | dir | payload                          | accepted when
// in_i    | in  | key[30:0], last                  | valid && ready
// out_o   | out | sorted_key[30:0], final_res, ovf | valid && ready
// Loading takes one key per cycle; ready stays high until a last key.
// Each digit pass runs a count sweep, a prefix sum and a scatter sweep through
// the entry memories; up to ten passes, set by the largest key.
// Each result goes through the read, capture and hold states, waiting in hold on any out stall.
// Reset clears all control state; memory contents stay undefined.
module lsd_radix_sort_top #(
  parameter int unsigned MaxItems = lsd_pkg::MaxItems
) (
  input logic       clk_i,
  input logic       rst_ni,
  lsd_in_if.sink    in_i,
  lsd_out_if.source out_o
);
  import lsd_pkg::*;

  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_CNT  = 4'd3;
  localparam logic [3:0] S_PFX  = 4'd4;
  localparam logic [3:0] S_SCT  = 4'd5;
  localparam logic [3:0] S_NXT  = 4'd6;
  localparam logic [3:0] S_NXTW = 4'd7;
  localparam logic [3:0] S_ORD  = 4'd8;
  localparam logic [3:0] S_OWT  = 4'd9;
  localparam logic [3:0] S_OHD  = 4'd10;

  logic [3:0]      state_q;
  logic [CW-1:0]   n_q;
  logic [KeyW-1:0] lq_q;
  logic            drop_q;
  logic            sel_q;
  logic [CW-1:0]   ic_q;
  logic [3:0]      j_q;
  logic [CW-1:0]   acc_q;
  logic [CW-1:0]   counts_q [Radix];
  logic [AW-1:0]   oi_q;
  logic            rv_q;
  logic            ovalid_q;
  logic [KeyW-1:0] okey_q;
  logic            ofinal_q;
  logic            oovf_q;

  logic            in_acc;
  logic            rd_en;
  logic [AW-1:0]   raddr;
  logic            ld_we;
  logic            sc_we;
  logic [AW-1:0]   sc_addr;
  logic [CW-1:0]   pos;
  logic [CW-1:0]   ic_dec;
  entry_t          ld_data;
  entry_t          sc_data;
  entry_t          rd0;
  entry_t          rd1;
  entry_t          rdata;
  logic            we0;
  logic            we1;
  logic [AW-1:0]   wa0;
  logic [AW-1:0]   wa1;
  entry_t          wd0;
  entry_t          wd1;
  dig_req_t        dreq;
  dig_rsp_t        drsp;
  dig_req_t        lreq;
  dig_rsp_t        lrsp;
  logic            cnt_done;
  logic            sct_done;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;

  assign ld_we   = in_acc && (n_q < CW'(MaxItems));
  assign ld_data = '{key: in_i.key, q: in_i.key};

  assign ic_dec = ic_q - CW'(1);
  assign pos    = counts_q[drsp.digit] - CW'(1);
  assign sc_we  = (state_q == S_SCT) && drsp.valid;
  assign sc_addr = pos[AW-1:0];
  assign sc_data = '{key: drsp.key, q: drsp.quot};

  always_comb begin
    rd_en = 1'b0;
    raddr = oi_q;
    case (state_q)
      S_CNT: begin
        rd_en = (ic_q != n_q);
        raddr = ic_q[AW-1:0];
      end
      S_SCT: begin
        rd_en = (ic_q != '0);
        raddr = ic_dec[AW-1:0];
      end
      S_ORD: begin
        rd_en = 1'b1;
        raddr = oi_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign we0 = (ld_we && !sel_q) || (sc_we && sel_q);
  assign we1 = (ld_we && sel_q) || (sc_we && !sel_q);
  assign wa0 = sel_q ? sc_addr : n_q[AW-1:0];
  assign wa1 = sel_q ? n_q[AW-1:0] : sc_addr;
  assign wd0 = sel_q ? sc_data : ld_data;
  assign wd1 = sel_q ? ld_data : sc_data;
  assign rdata = sel_q ? rd1 : rd0;

  lsd_mem #(.Depth(MaxItems), .AddrW(AW)) u_mem0 (
    .clk_i, .we_i(we0), .waddr_i(wa0), .wdata_i(wd0), .raddr_i(raddr), .rdata_o(rd0)
  );

  lsd_mem #(.Depth(MaxItems), .AddrW(AW)) u_mem1 (
    .clk_i, .we_i(we1), .waddr_i(wa1), .wdata_i(wd1), .raddr_i(raddr), .rdata_o(rd1)
  );

  assign dreq.valid = rv_q && ((state_q == S_CNT) || (state_q == S_SCT));
  assign dreq.key   = rdata.key;
  assign dreq.q     = rdata.q;

  lsd_digit u_digit (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign lreq.valid = (state_q == S_NXT);
  assign lreq.key   = lq_q;
  assign lreq.q     = lq_q;

  lsd_digit u_limit (.clk_i, .rst_ni, .req_i(lreq), .rsp_o(lrsp));

  assign cnt_done = (ic_q == n_q) && !rv_q && !drsp.valid;
  assign sct_done = (ic_q == '0) && !rv_q && !drsp.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      n_q      <= '0;
      lq_q     <= '0;
      drop_q   <= 1'b0;
      sel_q    <= 1'b0;
      ic_q     <= '0;
      j_q      <= '0;
      acc_q    <= '0;
      oi_q     <= '0;
      rv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      okey_q   <= '0;
      ofinal_q <= 1'b0;
      oovf_q   <= 1'b0;
      for (int i = 0; i < Radix; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      rv_q <= rd_en;
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (ld_we) begin
              n_q <= n_q + CW'(1);
              if (in_i.key > lq_q) begin
                lq_q <= in_i.key;
              end
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.last) begin
              state_q <= S_CHK;
            end
          end
        end
        S_CHK: begin
          oi_q    <= '0;
          state_q <= (lq_q == '0) ? S_ORD : S_CLR;
        end
        S_CLR: begin
          for (int i = 0; i < Radix; i++) begin
            counts_q[i] <= '0;
          end
          acc_q   <= '0;
          ic_q    <= '0;
          state_q <= S_CNT;
        end
        S_CNT: begin
          if (rd_en) begin
            ic_q <= ic_q + CW'(1);
          end
          if (drsp.valid) begin
            counts_q[drsp.digit] <= counts_q[drsp.digit] + CW'(1);
          end
          if (cnt_done) begin
            j_q     <= '0;
            state_q <= S_PFX;
          end
        end
        S_PFX: begin
          counts_q[j_q] <= acc_q + counts_q[j_q];
          acc_q         <= acc_q + counts_q[j_q];
          j_q           <= j_q + 4'd1;
          if (j_q == 4'(Radix - 1)) begin
            ic_q    <= n_q;
            state_q <= S_SCT;
          end
        end
        S_SCT: begin
          if (rd_en) begin
            ic_q <= ic_dec;
          end
          if (drsp.valid) begin
            counts_q[drsp.digit] <= pos;
          end
          if (sct_done) begin
            state_q <= S_NXT;
          end
        end
        S_NXT: begin
          sel_q   <= !sel_q;
          state_q <= S_NXTW;
        end
        S_NXTW: begin
          lq_q    <= lrsp.quot;
          state_q <= S_CHK;
        end
        S_ORD: begin
          state_q <= S_OWT;
        end
        S_OWT: begin
          okey_q   <= rdata.key;
          ofinal_q <= ((CW'(oi_q) + CW'(1)) == n_q);
          oovf_q   <= drop_q;
          ovalid_q <= 1'b1;
          state_q  <= S_OHD;
        end
        S_OHD: begin
          if (out_o.ready) begin
            ovalid_q <= 1'b0;
            if (ofinal_q) begin
              n_q     <= '0;
              lq_q    <= '0;
              drop_q  <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              oi_q    <= oi_q + AW'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.sorted_key = okey_q;
  assign out_o.final_res  = ofinal_q;
  assign out_o.overflow   = oovf_q;

endmodule

// File: hw/rtl/lsd_chk.sv
`include "lsd_radix_sort_top_defines.svh"

module lsd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_final_i,
  input logic [30:0] out_key_i
);

  `LSD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_key_i), "request dropped or changed while stalled")
  `LSD_ASSERT(a_no_load_in_run, !(out_valid_i && in_ready_i), "input taken while a result is pending")
  `LSD_ASSERT_NEXT(a_run_continues, out_valid_i && out_ready_i && !out_final_i, !in_ready_i, "input reopened before final result")
  `LSD_ASSERT_NEXT(a_last_closes, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "input still open after last request")

endmodule

bind lsd_radix_sort_top lsd_chk u_lsd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_final_i (out_o.final_res),
  .out_key_i   (out_o.sorted_key)
);
